// ===== rtl/u2ea_pkg.sv =====
// ----------------------------------------------------------------------------
// u2ea_pkg
// Shared types, character constants and helper functions for the UTF-8 to
// escaped ASCII converter.
// ----------------------------------------------------------------------------
package u2ea_pkg;

    // Decoder state widths
    localparam int ACC_W   = 22;
    localparam int REM_W   = 2;

    // Token queue between front and back end
    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    // Longest escape: backslash, u, four hex digits
    localparam int HEX_LEN = 6;
    localparam int IDX_W   = $clog2(HEX_LEN);

    // ASCII codes used by the escaper
    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_BSLASH = 7'h5c;
    localparam logic [6:0] CH_BEL    = 7'h07;
    localparam logic [6:0] CH_BS     = 7'h08;
    localparam logic [6:0] CH_TAB    = 7'h09;
    localparam logic [6:0] CH_LF     = 7'h0a;
    localparam logic [6:0] CH_FF     = 7'h0c;
    localparam logic [6:0] CH_CR     = 7'h0d;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_DEL    = 7'h7f;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_LA     = 7'h61;
    localparam logic [6:0] CH_LB     = 7'h62;
    localparam logic [6:0] CH_LF_LTR = 7'h66;
    localparam logic [6:0] CH_LN     = 7'h6e;
    localparam logic [6:0] CH_LR     = 7'h72;
    localparam logic [6:0] CH_LT     = 7'h74;
    localparam logic [6:0] CH_LU     = 7'h75;

    // How a decoded code point is written out
    typedef enum logic [1:0] {
        TK_END,     // value zero: end of text marker
        TK_PRINT,   // printable, passes through
        TK_ESC,     // backslash and a letter
        TK_HEX      // backslash, u, four hex digits
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] data;  // char, escape letter or low 16 bits of code
    } tok_t;

    // One queue entry: the tokens caused by one input byte
    typedef struct packed {
        tok_t tok0;
        tok_t tok1;
        logic pair;         // tok1 follows tok0
    } entry_t;

    // Classify a decoded code point
    function automatic tok_t classify(input logic [ACC_W-1:0] v);
        tok_t t;
        logic low7;
        t.kind = TK_HEX;
        t.data = v[15:0];
        low7   = (v[ACC_W-1:7] == '0);
        if (v == '0) begin
            t.kind = TK_END;
            t.data = '0;
        end else if (low7) begin
            case (v[6:0])
                CH_QUOTE:  begin t.kind = TK_ESC; t.data = {9'd0, CH_QUOTE};  end
                CH_BSLASH: begin t.kind = TK_ESC; t.data = {9'd0, CH_BSLASH}; end
                CH_BEL:    begin t.kind = TK_ESC; t.data = {9'd0, CH_LA};     end
                CH_BS:     begin t.kind = TK_ESC; t.data = {9'd0, CH_LB};     end
                CH_FF:     begin t.kind = TK_ESC; t.data = {9'd0, CH_LF_LTR}; end
                CH_TAB:    begin t.kind = TK_ESC; t.data = {9'd0, CH_LT};     end
                CH_CR:     begin t.kind = TK_ESC; t.data = {9'd0, CH_LR};     end
                CH_LF:     begin t.kind = TK_ESC; t.data = {9'd0, CH_LN};     end
                default:
                begin
                    if (v[6:0] >= CH_SPACE && v[6:0] != CH_DEL) begin
                        t.kind = TK_PRINT;
                    end
                end
            endcase
        end
        return t;
    endfunction

    // Number of output bytes for a token, minus one
    function automatic logic [IDX_W-1:0] tok_last_idx(input tok_kind_t k);
        logic [IDX_W-1:0] n;
        unique case (k)
            TK_END:   n = '0;
            TK_PRINT: n = '0;
            TK_ESC:   n = IDX_W'(1);
            TK_HEX:   n = IDX_W'(HEX_LEN - 1);
            default:  n = '0;
        endcase
        return n;
    endfunction

    // Lower-case hex digit
    function automatic logic [6:0] hex_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {3'd0, d};
        end else begin
            c = CH_LA + {3'd0, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

// ===== rtl/utf8_to_escaped_ascii.sv =====
// ----------------------------------------------------------------------------
// utf8_to_escaped_ascii
// Lenient UTF-8 decoder producing C-string escaped ASCII text.
// ----------------------------------------------------------------------------
// Accepts one UTF-8 byte per cycle while the four-entry token queue has room;
// each byte yields zero to twelve output characters (a flushed partial code
// point and the fresh one), written one per cycle by the escape writer while
// out_stall is low. Plain printable ASCII therefore streams at one byte per
// cycle; a two-byte escape gives two output characters and a \uXXXX escape
// six, and the output port's single character per cycle sets the sustained
// rate, the queue absorbing short bursts. The last character caused by an
// input byte has last set; a decoded zero gives one transaction with
// text_end set and no character, and the decoder then starts a new text.
module utf8_to_escaped_ascii
    import u2ea_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] out_byte,
    output logic       has_byte,
    output logic       text_end,
    output logic       last
);

    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   full;
    logic   head_vld;
    entry_t head;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Decoder front end
    u2ea_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (in_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    // Token queue
    u2ea_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_vld   (head_vld),
        .head       (head)
    );

    // Escape writer
    u2ea_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_vld  (head_vld),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .text_end  (text_end),
        .last      (last)
    );

endmodule

// ===== rtl/u2ea_front.sv =====
// ----------------------------------------------------------------------------
// u2ea_front
// UTF-8 decoder: accumulates continuation bytes, flushes partial sequences
// and turns each finished code point into an escape token.
// ----------------------------------------------------------------------------
module u2ea_front
    import u2ea_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output entry_t     push_entry
);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [REM_W-1:0] rem_reg, rem_next;

    // Decode one byte against the pending sequence
    always_comb
    begin
        logic             is_cont;
        logic             fresh;
        logic             ended;
        logic             have0;
        logic             have1;
        logic [ACC_W-1:0] acc_sh;
        logic [REM_W-1:0] rem_dec;
        logic [1:0]       extra;
        logic [6:0]       mask;
        tok_t             t0;
        tok_t             t1;
        tok_t             tf;
        logic             tf_vld;

        is_cont  = (in_byte[7:6] == 2'b10);
        fresh    = 1'b1;
        ended    = 1'b0;
        have0    = 1'b0;
        have1    = 1'b0;
        acc_next = acc_reg;
        rem_next = rem_reg;
        acc_sh   = {acc_reg[ACC_W-7:0], in_byte[5:0]};
        rem_dec  = rem_reg - REM_W'(1);
        t0       = classify(acc_reg);
        t1       = t0;
        tf       = t0;
        tf_vld   = 1'b0;

        // Pending sequence: extend or flush
        if (rem_reg != '0) begin
            fresh = 1'b0;
            if (is_cont) begin
                acc_next = acc_sh;
                rem_next = rem_dec;
                if (rem_dec == '0) begin
                    t0       = classify(acc_sh);
                    have0    = 1'b1;
                    ended    = (acc_sh == '0);
                    acc_next = '0;
                end
            end else begin
                t0       = classify(acc_reg);
                have0    = 1'b1;
                ended    = (acc_reg == '0);
                acc_next = '0;
                rem_next = '0;
                fresh    = !ended;
            end
        end

        // Lead byte count: leading ones in bits 6..4
        if (!in_byte[6]) begin
            extra = 2'd0;
        end else if (!in_byte[5]) begin
            extra = 2'd1;
        end else if (!in_byte[4]) begin
            extra = 2'd2;
        end else begin
            extra = 2'd3;
        end
        mask = 7'h7f >> extra;

        // Fresh byte decode
        if (fresh) begin
            if (!in_byte[7]) begin
                tf     = classify({15'd0, in_byte[6:0]});
                tf_vld = 1'b1;
                ended  = ended || (in_byte[6:0] == '0);
            end else if (extra == 2'd0) begin
                tf     = classify({15'd0, in_byte[6:0]});
                tf_vld = 1'b1;
                ended  = ended || (in_byte[6:0] == '0);
            end else begin
                acc_next = {15'd0, in_byte[6:0] & mask};
                rem_next = extra;
            end
        end

        if (tf_vld) begin
            if (have0) begin
                t1    = tf;
                have1 = 1'b1;
            end else begin
                t0    = tf;
                have0 = 1'b1;
            end
        end

        if (ended) begin
            acc_next = '0;
            rem_next = '0;
        end

        push            = accept && have0;
        push_entry.tok0 = t0;
        push_entry.tok1 = t1;
        push_entry.pair = have1;
    end

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg <= '0;
            rem_reg <= '0;
        end else if (accept) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

endmodule

// ===== rtl/u2ea_fifo.sv =====
// ----------------------------------------------------------------------------
// u2ea_fifo
// Short token queue between the decoder and the escape writer.
// ----------------------------------------------------------------------------
module u2ea_fifo
    import u2ea_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   head_vld,
    output entry_t head
);

    entry_t         mem_reg [QDEPTH];
    logic [QAW-1:0] wptr_reg, rptr_reg;
    logic [QCW-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCW'(QDEPTH));
    assign head_vld = (cnt_reg != '0);
    assign head     = mem_reg[rptr_reg];

    // Occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + QCW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + QAW'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + QAW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/u2ea_back.sv =====
// ----------------------------------------------------------------------------
// u2ea_back
// Escape writer: expands each queued token into its output characters, one
// per cycle while out_stall is low, into an output register.
// ----------------------------------------------------------------------------
module u2ea_back
    import u2ea_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_vld,
    input  entry_t     head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] out_byte,
    output logic       has_byte,
    output logic       text_end,
    output logic       last
);

    logic             sel_reg, sel_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             vld_reg, vld_next;
    logic [6:0]       byte_reg, byte_next;
    logic             has_reg, has_next;
    logic             end_reg, end_next;
    logic             last_reg, last_next;

    // Next character selection
    always_comb
    begin
        tok_t             t;
        logic             adv;
        logic             tok_done;
        logic             entry_done;
        logic [IDX_W-1:0] lidx;

        t          = sel_reg ? head.tok1 : head.tok0;
        lidx       = tok_last_idx(t.kind);
        adv        = head_vld && (!vld_reg || !out_stall);
        tok_done   = (idx_reg == lidx);
        entry_done = tok_done && (sel_reg || !head.pair);

        sel_next  = sel_reg;
        idx_next  = idx_reg;
        vld_next  = vld_reg && out_stall;
        byte_next = byte_reg;
        has_next  = has_reg;
        end_next  = end_reg;
        last_next = last_reg;
        pop       = 1'b0;

        if (adv) begin
            vld_next  = 1'b1;
            has_next  = 1'b1;
            end_next  = 1'b0;
            last_next = entry_done;
            byte_next = CH_BSLASH;
            unique case (t.kind)
                TK_END:
                begin
                    has_next  = 1'b0;
                    end_next  = 1'b1;
                    byte_next = '0;
                end
                TK_PRINT:
                begin
                    byte_next = t.data[6:0];
                end
                TK_ESC:
                begin
                    if (idx_reg != '0) begin
                        byte_next = t.data[6:0];
                    end
                end
                TK_HEX:
                begin
                    case (idx_reg)
                        IDX_W'(0): byte_next = CH_BSLASH;
                        IDX_W'(1): byte_next = CH_LU;
                        IDX_W'(2): byte_next = hex_char(t.data[15:12]);
                        IDX_W'(3): byte_next = hex_char(t.data[11:8]);
                        IDX_W'(4): byte_next = hex_char(t.data[7:4]);
                        default:   byte_next = hex_char(t.data[3:0]);
                    endcase
                end
                default:
                begin
                    byte_next = CH_BSLASH;
                end
            endcase

            if (tok_done) begin
                idx_next = '0;
                if (entry_done) begin
                    sel_next = 1'b0;
                    pop      = 1'b1;
                end else begin
                    sel_next = 1'b1;
                end
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sel_reg <= 1'b0;
            idx_reg <= '0;
            vld_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        has_reg  <= has_next;
        end_reg  <= end_next;
        last_reg <= last_next;
    end

    assign out_valid = vld_reg;
    assign out_byte  = byte_reg;
    assign has_byte  = has_reg;
    assign text_end  = end_reg;
    assign last      = last_reg;

    // Character index stays inside the longest escape
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(HEX_LEN - 1))
        else $error("character index out of range");

    // Second token is only selected while its entry is at the head
    a_sel_pair: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (head_vld && head.pair))
        else $error("second token selected without a pair");

    // End of text carries no character and closes its input byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && end_reg) |-> (!has_reg && last_reg))
        else $error("end of text marker malformed");

endmodule

// ===== tb/utf8_to_escaped_ascii_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_escaped_ascii_tb
// Drives UTF-8 byte streams into the escaped ASCII converter and checks each
// output character against an in-bench decoder and escaper model.
// ----------------------------------------------------------------------------
// A directed run covers the escape classes, lead byte forms, truncated
// sequences and text end. Random well-formed, broken and noise sequences
// follow under three sender/receiver idle profiles.
module utf8_to_escaped_ascii_tb;
    import u2ea_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 20;
    localparam int PHASE_ITEMS = 170;

    // One expected output transaction
    typedef struct packed {
        logic [6:0] out_byte;
        logic       has_byte;
        logic       text_end;
        logic       last;
    } char_xact_t;

    // Decoder/escaper model plus store of expected characters
    class escape_scoreboard;
        logic [21:0] code_acc;
        logic [1:0]  cont_left;
        char_xact_t  pending_chars[$];
        int          errors;
        string       hex_digits;

        function new();
            code_acc   = '0;
            cont_left  = '0;
            errors     = 0;
            hex_digits = "0123456789abcdef";
        endfunction

        function void push_char(logic [6:0] ch, logic hb, logic te);
            char_xact_t x;
            x.out_byte = ch;
            x.has_byte = hb;
            x.text_end = te;
            x.last     = 1'b0;
            pending_chars.push_back(x);
        endfunction

        // Escapes one code point; returns 1 when it ends the text
        function bit escape_code(logic [21:0] c);
            logic [6:0] letter;
            bit         two_char;
            if (c == '0) begin
                push_char(7'd0, 1'b0, 1'b1);
                return 1'b1;
            end
            two_char = 1'b1;
            letter   = '0;
            case (c)
                CH_QUOTE:  letter = CH_QUOTE;
                CH_BSLASH: letter = CH_BSLASH;
                CH_BEL:    letter = CH_LA;
                CH_BS:     letter = CH_LB;
                CH_FF:     letter = CH_LF_LTR;
                CH_TAB:    letter = CH_LT;
                CH_CR:     letter = CH_LR;
                CH_LF:     letter = CH_LN;
                default:   two_char = 1'b0;
            endcase
            if (two_char) begin
                push_char(CH_BSLASH, 1'b1, 1'b0);
                push_char(letter, 1'b1, 1'b0);
            end else if (c >= CH_SPACE && c < CH_DEL) begin
                push_char(c[6:0], 1'b1, 1'b0);
            end else begin
                push_char(CH_BSLASH, 1'b1, 1'b0);
                push_char(CH_LU, 1'b1, 1'b0);
                push_char(7'(hex_digits.getc(c[15:12])), 1'b1, 1'b0);
                push_char(7'(hex_digits.getc(c[11:8])), 1'b1, 1'b0);
                push_char(7'(hex_digits.getc(c[7:4])), 1'b1, 1'b0);
                push_char(7'(hex_digits.getc(c[3:0])), 1'b1, 1'b0);
            end
            return 1'b0;
        endfunction

        // Accepted input byte: decode and queue the characters it causes
        function void note_input(logic [7:0] b);
            int          first_idx;
            int          extra;
            bit          ended;
            bit          fresh;
            logic [21:0] partial;
            first_idx = pending_chars.size();
            ended     = 1'b0;
            fresh     = 1'b1;
            // pending sequence: extend it or flush the partial value
            if (cont_left != '0) begin
                if (b[7:6] == 2'b10) begin
                    code_acc  = {code_acc[15:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == '0) begin
                        ended    = escape_code(code_acc);
                        code_acc = '0;
                    end
                    fresh = 1'b0;
                end else begin
                    partial   = code_acc;
                    code_acc  = '0;
                    cont_left = '0;
                    ended     = escape_code(partial);
                    if (ended)
                        fresh = 1'b0;
                end
            end
            // fresh byte: ASCII, stray continuation or lead
            if (fresh) begin
                if (!b[7]) begin
                    ended = escape_code({14'd0, b});
                end else begin
                    extra = 0;
                    while (extra < 3 && b[6 - extra])
                        extra++;
                    if (extra == 0) begin
                        ended = escape_code({15'd0, b[6:0]});
                    end else begin
                        code_acc  = {14'd0, b & (8'h7f >> extra)};
                        cont_left = extra[1:0];
                    end
                end
            end
            if (ended) begin
                code_acc  = '0;
                cont_left = '0;
            end
            if (pending_chars.size() > first_idx)
                pending_chars[pending_chars.size() - 1].last = 1'b1;
        endfunction

        // Accepted output transaction: compare with oldest expectation
        function void check_result(logic [6:0] ob, logic hb, logic te, logic la);
            char_xact_t x;
            if (pending_chars.size() == 0) begin
                $error("unexpected output: out_byte %h has_byte %b text_end %b last %b",
                       ob, hb, te, la);
                errors++;
                return;
            end
            x = pending_chars.pop_front();
            if (ob !== x.out_byte) begin
                $error("out_byte mismatch: expected %h, actual %h", x.out_byte, ob);
                errors++;
            end
            if (hb !== x.has_byte) begin
                $error("has_byte mismatch: expected %b, actual %b", x.has_byte, hb);
                errors++;
            end
            if (te !== x.text_end) begin
                $error("text_end mismatch: expected %b, actual %b", x.text_end, te);
                errors++;
            end
            if (la !== x.last) begin
                $error("last mismatch: expected %b, actual %b", x.last, la);
                errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] out_byte;
    logic       has_byte;
    logic       text_end;
    logic       last;

    escape_scoreboard board = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;
    int cycles         = 0;

    utf8_to_escaped_ascii dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .text_end  (text_end),
        .last      (last)
    );

    // Clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver stall, changed on the falling edge
    always @(negedge clk)
    begin
        out_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Monitor: input before output so a same-edge result finds its expectation
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                board.note_input(in_byte);
            if (out_valid && !out_stall)
                board.check_result(out_byte, has_byte, text_end, last);
        end
    end

    // One input transaction; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_byte  = b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Lead byte for an n-byte sequence followed by some continuations
    task automatic send_sequence(input int n, input int conts);
        logic [7:0] lead;
        lead = 8'($urandom_range(0, 255));
        case (n)
            2:       lead[7:5] = 3'b110;
            3:       lead[7:4] = 4'b1110;
            default: lead[7:3] = 5'b11110;
        endcase
        send_byte(lead);
        repeat (conts)
            send_byte({2'b10, 6'($urandom_range(0, 63))});
    endtask

    // Random mix: mostly well-formed text, some broken sequences and noise
    task automatic send_random(input int count);
        int stop_at;
        int pick;
        int n;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_byte(8'h00);
            end else if (pick < 35) begin
                send_byte(8'($urandom_range(1, 127)));
            end else if (pick < 75) begin
                n = $urandom_range(2, 4);
                send_sequence(n, n - 1);
            end else if (pick < 85) begin
                n = $urandom_range(2, 4);
                send_sequence(n, $urandom_range(0, n - 2));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Directed bytes: escape classes, lead forms, truncation, text end
    logic [7:0] directed_bytes[] = '{
        8'h41, 8'h7e, 8'h7f, 8'h22, 8'h5c, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0c,
        8'h0d,
        8'hc3, 8'ha9,                       // two-byte sequence
        8'he2, 8'h82, 8'hac,                // three-byte sequence
        8'hff, 8'hbf, 8'hbf, 8'hbf,         // over-long lead, wide value
        8'h80,                              // stray continuation of zero
        8'he2, 8'h41,                       // truncated, then fresh byte
        8'he0, 8'h41,                       // zero partial: flushing byte dropped
        8'hc3, 8'h00,                       // partial flush, then terminator
        8'h00
    };

    // Main sequence
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct  = 10;
        recv_stall_pct = 75;
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        send_random(PHASE_ITEMS);

        send_idle_pct  = 75;
        recv_stall_pct = 10;
        send_random(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(PHASE_ITEMS);
        in_valid = 1'b0;

        // drain, then watch for stray output
        while (board.pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
